/* rtl/gas_pkg.sv */
// Shared types and constants for the grid A* path search block.
// Used by every module of the block except gas_ram; depends on nothing.
package gas_pkg;

    localparam int MAX_DIM       = 16;
    localparam int COORD_W       = 4;
    localparam int CELL_W        = 8;
    localparam int CELLS         = MAX_DIM * MAX_DIM;
    localparam int SIZE_W        = 5;
    localparam int G_W           = 9;
    localparam int F_W           = 10;
    localparam int SEQ_W         = 11;
    localparam int DIR_W         = 3;
    localparam int LEN_W         = 9;
    localparam int OPEN_DEPTH_DEF = 1024;

    localparam logic [DIR_W-1:0] DIR_NONE = 3'd4;

    typedef enum logic [1:0] {
        KIND_WALL   = 2'd0,
        KIND_SEARCH = 2'd1,
        KIND_PATH   = 2'd2,
        KIND_NONE   = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_FOUND     = 2'd0,
        ST_NO_PATH   = 2'd1,
        ST_BAD_START = 2'd2,
        ST_OVERFLOW  = 2'd3
    } t_status;

    typedef enum logic {
        CFG_SIZE_X = 1'b0,
        CFG_SIZE_Y = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic [F_W-1:0]    f;
        logic [G_W-1:0]    g;
        logic [CELL_W-1:0] loc;
        logic [DIR_W-1:0]  dir;
    } t_open_req;

    typedef struct packed {
        logic [F_W-1:0]    f;
        logic [G_W-1:0]    g;
        logic [SEQ_W-1:0]  seq;
        logic [CELL_W-1:0] loc;
        logic [DIR_W-1:0]  dir;
    } t_open_ent;

    typedef struct packed {
        logic clr;
        logic push;
        logic pop;
    } t_open_cmd;

    typedef struct packed {
        logic done;
        logic empty;
        logic full;
    } t_open_sts;

    typedef struct packed {
        t_kind              kind;
        logic [COORD_W-1:0] cell_x;
        logic [COORD_W-1:0] cell_y;
        logic               wall;
        logic [COORD_W-1:0] start_x;
        logic [COORD_W-1:0] start_y;
        logic [COORD_W-1:0] goal_x;
        logic [COORD_W-1:0] goal_y;
        logic [7:0]         path_index;
    } t_cmd;

    typedef struct packed {
        t_status            status;
        logic [LEN_W-1:0]   path_length;
        logic [COORD_W-1:0] step_x;
        logic [COORD_W-1:0] step_y;
    } t_res;

    typedef enum logic [1:0] {
        O_IDLE,
        O_SCAN,
        O_LAST
    } t_open_state;

    typedef enum logic [3:0] {
        S_CLR,
        S_IDLE,
        S_PREP,
        S_POP,
        S_PWAIT,
        S_CHK,
        S_NB,
        S_NBCHK,
        S_TR,
        S_TRW,
        S_RDP,
        S_RES
    } t_srch_state;

endpackage

/* rtl/grid_astar_path_search.sv */
// Top level of the grid A* path search: stream ports, size registers,
// result register. Depends on gas_pkg, gas_search, gas_open.
//
// channel  | dir | fields
// s_axis   | in  | tuser: kind; tdata: cell_x, cell_y, wall, start_x, start_y,
//          |     |   goal_x, goal_y, path_index
// m_axis   | out | tdata: status, path_length, step_x, step_y
// cfg      | in  | write-only: size_x (index 0), size_y (index 1)
//
// A search first clears the node map, then for each popped entry scans the
// open set over all its entries and checks the neighbors; the scan of the
// open set RAM dominates. After reset a clearing pass of the wall and node
// maps runs with tready low. A waiting result sits in the output register
// while the next item is taken.
module grid_astar_path_search
    import gas_pkg::*;
#(
    parameter int OPEN_DEPTH = OPEN_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    // [3:0] cell_x, [7:4] cell_y, [8] wall, [12:9] start_x, [16:13] start_y,
    // [20:17] goal_x, [24:21] goal_y, [32:25] path_index, [39:33] zero
    input  logic [39:0]       i_s_axis_tdata,
    // [1:0] kind
    input  logic [1:0]        i_s_axis_tuser,
    output logic              o_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    // [1:0] status, [10:2] path_length, [14:11] step_x, [18:15] step_y, [23:19] zero
    output logic [23:0]       o_m_axis_tdata,
    input  logic              i_cfg_we,
    input  logic              i_cfg_idx,
    input  logic [SIZE_W-1:0] i_cfg_wdata
);
    logic [SIZE_W-1:0] r_size_x, r_size_y;
    logic              r_out_valid;
    t_res              r_out;

    logic [SIZE_W-1:0] lim_x, lim_y;
    t_cmd              cmd;
    logic              res_valid, res_ready;
    t_res              res;
    t_open_cmd         open_cmd;
    t_open_req         open_req;
    t_open_sts         open_sts;
    t_open_ent         open_ent;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_x <= SIZE_W'(MAX_DIM);
            r_size_y <= SIZE_W'(MAX_DIM);
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_SIZE_X: r_size_x <= i_cfg_wdata;
                CFG_SIZE_Y: r_size_y <= i_cfg_wdata;
                default: r_size_x <= r_size_x;
            endcase
        end
    end

    // sizes above the map dimension act as the full map
    assign lim_x = (r_size_x > SIZE_W'(MAX_DIM)) ? SIZE_W'(MAX_DIM) : r_size_x;
    assign lim_y = (r_size_y > SIZE_W'(MAX_DIM)) ? SIZE_W'(MAX_DIM) : r_size_y;

    assign cmd = '{
        kind:       t_kind'(i_s_axis_tuser),
        cell_x:     i_s_axis_tdata[3:0],
        cell_y:     i_s_axis_tdata[7:4],
        wall:       i_s_axis_tdata[8],
        start_x:    i_s_axis_tdata[12:9],
        start_y:    i_s_axis_tdata[16:13],
        goal_x:     i_s_axis_tdata[20:17],
        goal_y:     i_s_axis_tdata[24:21],
        path_index: i_s_axis_tdata[32:25]
    };

    gas_search u_search (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd_valid(i_s_axis_tvalid),
        .o_cmd_ready(o_s_axis_tready),
        .i_cmd      (cmd),
        .i_lim_x    (lim_x),
        .i_lim_y    (lim_y),
        .o_res_valid(res_valid),
        .i_res_ready(res_ready),
        .o_res      (res),
        .o_open_cmd (open_cmd),
        .o_open_req (open_req),
        .i_open_sts (open_sts),
        .i_open_ent (open_ent)
    );

    gas_open #(.OPEN_DEPTH(OPEN_DEPTH)) u_open (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (open_cmd),
        .i_req  (open_req),
        .o_sts  (open_sts),
        .o_ent  (open_ent)
    );

    // output register: load when empty or draining this cycle
    assign res_ready = !r_out_valid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {5'd0, r_out.step_y, r_out.step_x, r_out.path_length,
                              r_out.status};
endmodule

/* rtl/gas_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module gas_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* rtl/gas_open.sv */
// Open set of the search: unordered entries in one RAM, pop by a linear scan
// for least (f, insert order). Depends on gas_pkg and gas_ram.
module gas_open
    import gas_pkg::*;
#(
    parameter int OPEN_DEPTH = OPEN_DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_open_cmd i_cmd,
    input  t_open_req i_req,
    output t_open_sts o_sts,
    output t_open_ent o_ent
);
    localparam int AW = $clog2(OPEN_DEPTH);
    localparam int CW = $clog2(OPEN_DEPTH + 1);

    t_open_state      r_state, n_state;
    logic [CW-1:0]    r_count, n_count;
    logic [SEQ_W-1:0] r_seq, n_seq;
    logic [CW-1:0]    r_ia, n_ia;
    logic [AW-1:0]    r_pidx, n_pidx;
    logic             r_have, n_have;
    t_open_ent        r_best, n_best;
    logic [AW-1:0]    r_bidx, n_bidx;

    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    t_open_ent     ram_wdata, ram_rdata;
    logic [CW-1:0] last_idx;
    logic          better;

    gas_ram #(.WIDTH($bits(t_open_ent)), .DEPTH(OPEN_DEPTH)) u_heap_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= O_IDLE;
            r_count <= '0;
            r_seq   <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_seq   <= n_seq;
        end
        r_ia   <= n_ia;
        r_pidx <= n_pidx;
        r_have <= n_have;
        r_best <= n_best;
        r_bidx <= n_bidx;
    end

    assign last_idx = r_count - CW'(1);
    assign better   = !r_have || (ram_rdata.f < r_best.f) ||
                      ((ram_rdata.f == r_best.f) && (ram_rdata.seq < r_best.seq));

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_seq     = r_seq;
        n_ia      = r_ia;
        n_pidx    = r_pidx;
        n_have    = r_have;
        n_best    = r_best;
        n_bidx    = r_bidx;
        ram_we    = 1'b0;
        ram_waddr = r_count[AW-1:0];
        ram_wdata = '{f: i_req.f, g: i_req.g, seq: r_seq, loc: i_req.loc, dir: i_req.dir};
        ram_raddr = '0;
        o_sts     = '{done: 1'b0, empty: (r_count == '0), full: (r_count == CW'(OPEN_DEPTH))};
        unique case (r_state)
            O_IDLE: begin
                priority if (i_cmd.clr) begin
                    n_count = '0;
                    n_seq   = '0;
                end else if (i_cmd.push) begin
                    ram_we  = 1'b1;
                    n_count = r_count + CW'(1);
                    n_seq   = r_seq + SEQ_W'(1);
                end else if (i_cmd.pop) begin
                    ram_raddr = '0;
                    n_ia      = CW'(1);
                    n_pidx    = '0;
                    n_have    = 1'b0;
                    n_state   = O_SCAN;
                end else begin
                    n_state = O_IDLE;
                end
            end
            O_SCAN: begin
                // compare the entry returned by last cycle's read
                if (better) begin
                    n_best = ram_rdata;
                    n_bidx = r_pidx;
                end
                n_have = 1'b1;
                if (r_ia < r_count) begin
                    ram_raddr = r_ia[AW-1:0];
                    n_pidx    = r_ia[AW-1:0];
                    n_ia      = r_ia + CW'(1);
                end else begin
                    ram_raddr = last_idx[AW-1:0];
                    n_state   = O_LAST;
                end
            end
            O_LAST: begin
                // move the last entry into the hole left by the winner
                ram_we    = 1'b1;
                ram_waddr = r_bidx;
                ram_wdata = ram_rdata;
                n_count   = last_idx;
                o_sts.done = 1'b1;
                n_state   = O_IDLE;
            end
            default: n_state = O_IDLE;
        endcase
    end

    assign o_ent = r_best;
endmodule

/* rtl/gas_search.sv */
// Search sequencer: wall map, node map (closed flag and parent direction)
// and path store in RAMs, driving the open set. Depends on gas_pkg, gas_ram.
module gas_search
    import gas_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cmd_valid,
    output logic              o_cmd_ready,
    input  t_cmd              i_cmd,
    input  logic [SIZE_W-1:0] i_lim_x,
    input  logic [SIZE_W-1:0] i_lim_y,
    output logic              o_res_valid,
    input  logic              i_res_ready,
    output t_res              o_res,
    output t_open_cmd         o_open_cmd,
    output t_open_req         o_open_req,
    input  t_open_sts         i_open_sts,
    input  t_open_ent         i_open_ent
);
    t_srch_state        r_state, n_state;
    logic               r_clr_wall, n_clr_wall;
    logic [CELL_W-1:0]  r_clr_idx, n_clr_idx;
    logic [COORD_W-1:0] r_sx, n_sx, r_sy, n_sy, r_gx, n_gx, r_gy, n_gy;
    logic [7:0]         r_idx, n_idx;
    t_open_ent          r_cur, n_cur;
    logic [1:0]         r_d, n_d;
    logic [CELL_W-1:0]  r_nc, n_nc;
    logic [F_W-1:0]     r_nf, n_nf;
    logic [CELL_W-1:0]  r_tcell, n_tcell;
    logic [DIR_W-1:0]   r_tdir, n_tdir;
    logic [LEN_W-1:0]   r_len, n_len;
    t_status            r_status, n_status;
    logic [COORD_W-1:0] r_stx, n_stx, r_sty, n_sty;

    logic              wall_we, wall_wdata, wall_rdata;
    logic [CELL_W-1:0] wall_waddr, wall_raddr;
    logic              node_we;
    logic [3:0]        node_wdata, node_rdata;
    logic [CELL_W-1:0] node_waddr, node_raddr;
    logic              path_we;
    logic [CELL_W-1:0] path_waddr, path_wdata, path_raddr, path_rdata;

    logic [COORD_W-1:0] cx, cy, nx, ny, tx, ty, px, py;
    logic               nb_ok;
    logic [SIZE_W-1:0]  hx, hy;
    logic [G_W-1:0]     g_next;

    gas_ram #(.WIDTH(1), .DEPTH(CELLS)) u_wall_ram (
        .i_clk(i_clk), .i_we(wall_we), .i_waddr(wall_waddr), .i_wdata(wall_wdata),
        .i_raddr(wall_raddr), .o_rdata(wall_rdata)
    );
    gas_ram #(.WIDTH(4), .DEPTH(CELLS)) u_node_ram (
        .i_clk(i_clk), .i_we(node_we), .i_waddr(node_waddr), .i_wdata(node_wdata),
        .i_raddr(node_raddr), .o_rdata(node_rdata)
    );
    gas_ram #(.WIDTH(CELL_W), .DEPTH(CELLS)) u_path_ram (
        .i_clk(i_clk), .i_we(path_we), .i_waddr(path_waddr), .i_wdata(path_wdata),
        .i_raddr(path_raddr), .o_rdata(path_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLR;
            r_clr_wall <= 1'b1;
            r_clr_idx  <= '0;
            r_len      <= '0;
            r_status   <= ST_NO_PATH;
        end else begin
            r_state    <= n_state;
            r_clr_wall <= n_clr_wall;
            r_clr_idx  <= n_clr_idx;
            r_len      <= n_len;
            r_status   <= n_status;
        end
        r_sx    <= n_sx;
        r_sy    <= n_sy;
        r_gx    <= n_gx;
        r_gy    <= n_gy;
        r_idx   <= n_idx;
        r_cur   <= n_cur;
        r_d     <= n_d;
        r_nc    <= n_nc;
        r_nf    <= n_nf;
        r_tcell <= n_tcell;
        r_tdir  <= n_tdir;
        r_stx   <= n_stx;
        r_sty   <= n_sty;
    end

    // neighbor of the current cell in direction r_d
    assign cx     = r_cur.loc[CELL_W-1:COORD_W];
    assign cy     = r_cur.loc[COORD_W-1:0];
    assign g_next = r_cur.g + G_W'(1);

    always_comb begin
        nx    = cx;
        ny    = cy;
        nb_ok = 1'b0;
        unique case (r_d)
            2'd0: begin nx = cx - 4'd1; nb_ok = (cx != '0); end
            2'd1: begin nx = cx + 4'd1; nb_ok = ({1'b0, cx} + 5'd1) < i_lim_x; end
            2'd2: begin ny = cy - 4'd1; nb_ok = (cy != '0); end
            2'd3: begin ny = cy + 4'd1; nb_ok = ({1'b0, cy} + 5'd1) < i_lim_y; end
            default: nb_ok = 1'b0;
        endcase
        hx = (nx > r_gx) ? SIZE_W'(nx - r_gx) : SIZE_W'(r_gx - nx);
        hy = (ny > r_gy) ? SIZE_W'(ny - r_gy) : SIZE_W'(r_gy - ny);
    end

    // parent of the traced cell: step back against the stored direction
    assign tx = r_tcell[CELL_W-1:COORD_W];
    assign ty = r_tcell[COORD_W-1:0];
    always_comb begin
        px = tx;
        py = ty;
        unique case (r_tdir[1:0])
            2'd0: px = tx + 4'd1;
            2'd1: px = tx - 4'd1;
            2'd2: py = ty + 4'd1;
            2'd3: py = ty - 4'd1;
            default: px = tx;
        endcase
    end

    always_comb begin
        n_state    = r_state;
        n_clr_wall = r_clr_wall;
        n_clr_idx  = r_clr_idx;
        n_sx       = r_sx;
        n_sy       = r_sy;
        n_gx       = r_gx;
        n_gy       = r_gy;
        n_idx      = r_idx;
        n_cur      = r_cur;
        n_d        = r_d;
        n_nc       = r_nc;
        n_nf       = r_nf;
        n_tcell    = r_tcell;
        n_tdir     = r_tdir;
        n_len      = r_len;
        n_status   = r_status;
        n_stx      = r_stx;
        n_sty      = r_sty;
        wall_we    = 1'b0;
        wall_waddr = r_clr_idx;
        wall_wdata = 1'b0;
        wall_raddr = {nx, ny};
        node_we    = 1'b0;
        node_waddr = r_clr_idx;
        node_wdata = '0;
        node_raddr = {nx, ny};
        path_we    = 1'b0;
        path_waddr = r_len[CELL_W-1:0];
        path_wdata = r_tcell;
        path_raddr = i_cmd.path_index;
        o_cmd_ready = 1'b0;
        o_res_valid = 1'b0;
        o_open_cmd  = '0;
        o_open_req  = '{f: r_nf, g: g_next, loc: r_nc, dir: {1'b0, r_d}};
        unique case (r_state)
            S_CLR: begin
                node_we = 1'b1;
                wall_we = r_clr_wall;
                n_clr_idx = r_clr_idx + CELL_W'(1);
                if (r_clr_idx == CELL_W'(CELLS - 1)) begin
                    n_state    = r_clr_wall ? S_IDLE : S_PREP;
                    n_clr_wall = 1'b0;
                end
            end
            S_IDLE: begin
                o_cmd_ready = 1'b1;
                if (i_cmd_valid) begin
                    unique case (i_cmd.kind)
                        KIND_WALL: begin
                            wall_we    = 1'b1;
                            wall_waddr = {i_cmd.cell_x, i_cmd.cell_y};
                            wall_wdata = i_cmd.wall;
                        end
                        KIND_SEARCH: begin
                            n_sx  = i_cmd.start_x;
                            n_sy  = i_cmd.start_y;
                            n_gx  = i_cmd.goal_x;
                            n_gy  = i_cmd.goal_y;
                            n_len = '0;
                            n_clr_idx = '0;
                            o_open_cmd.clr = 1'b1;
                            n_state = S_CLR;
                        end
                        KIND_PATH: begin
                            n_idx   = i_cmd.path_index;
                            n_state = S_RDP;
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_RDP: begin
                if ({1'b0, r_idx} < r_len) begin
                    n_stx = path_rdata[CELL_W-1:COORD_W];
                    n_sty = path_rdata[COORD_W-1:0];
                end else begin
                    n_stx = '0;
                    n_sty = '0;
                end
                n_state = S_RES;
            end
            S_PREP: begin
                n_stx = '0;
                n_sty = '0;
                if (({1'b0, r_sx} >= i_lim_x) || ({1'b0, r_sy} >= i_lim_y)) begin
                    n_status = ST_BAD_START;
                    n_state  = S_RES;
                end else begin
                    o_open_cmd.push = 1'b1;
                    o_open_req = '{f: '0, g: '0, loc: {r_sx, r_sy}, dir: DIR_NONE};
                    n_state = S_POP;
                end
            end
            S_POP: begin
                if (i_open_sts.empty) begin
                    n_status = ST_NO_PATH;
                    n_state  = S_RES;
                end else begin
                    o_open_cmd.pop = 1'b1;
                    n_state = S_PWAIT;
                end
            end
            S_PWAIT: begin
                node_raddr = i_open_ent.loc;
                if (i_open_sts.done) begin
                    n_cur   = i_open_ent;
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                priority if (node_rdata[3]) begin
                    n_state = S_POP;
                end else if (r_cur.loc == {r_gx, r_gy}) begin
                    n_len   = '0;
                    n_tcell = r_cur.loc;
                    n_tdir  = r_cur.dir;
                    n_state = S_TR;
                end else begin
                    node_we    = 1'b1;
                    node_waddr = r_cur.loc;
                    node_wdata = {1'b1, r_cur.dir};
                    n_d        = 2'd0;
                    n_state    = S_NB;
                end
            end
            S_NB: begin
                if (nb_ok) begin
                    n_nc    = {nx, ny};
                    n_nf    = F_W'(g_next) + F_W'(hx) + F_W'(hy);
                    n_state = S_NBCHK;
                end else if (r_d == 2'd3) begin
                    n_state = S_POP;
                end else begin
                    n_d = r_d + 2'd1;
                end
            end
            S_NBCHK: begin
                priority if (wall_rdata || node_rdata[3]) begin
                    n_state = (r_d == 2'd3) ? S_POP : S_NB;
                    n_d     = r_d + 2'd1;
                end else if (i_open_sts.full) begin
                    n_status = ST_OVERFLOW;
                    n_len    = '0;
                    n_state  = S_RES;
                end else begin
                    o_open_cmd.push = 1'b1;
                    n_state = (r_d == 2'd3) ? S_POP : S_NB;
                    n_d     = r_d + 2'd1;
                end
            end
            S_TR: begin
                path_we = 1'b1;
                n_len   = r_len + LEN_W'(1);
                if (r_tdir[2] || (r_len == LEN_W'(CELLS - 1))) begin
                    n_status = ST_FOUND;
                    n_state  = S_RES;
                end else begin
                    n_tcell    = {px, py};
                    node_raddr = {px, py};
                    n_state    = S_TRW;
                end
            end
            S_TRW: begin
                n_tdir  = node_rdata[DIR_W-1:0];
                n_state = S_TR;
            end
            S_RES: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_res = '{status: r_status, path_length: r_len, step_x: r_stx, step_y: r_sty};
endmodule

/* rtl/gas_check.sv */
// Port-level checks on the result channel of the grid A* path search.
// Depends on gas_pkg; bound to grid_astar_path_search.
module gas_check
    import gas_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [23:0] o_m_axis_tdata
);
    // hold a stalled transfer
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("result transfer dropped or changed while stalled");

    a_len_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[10:2] <= 9'd256)
        else $error("path length above cell count");

    a_len_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tdata[1:0] != 2'(ST_FOUND)) |->
            o_m_axis_tdata[10:2] == 9'd0)
        else $error("path length nonzero without a found path");

    a_step_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tdata[14:11] != 4'd0 || o_m_axis_tdata[18:15] != 4'd0)
            |-> (o_m_axis_tdata[1:0] == 2'(ST_FOUND)) && (o_m_axis_tdata[10:2] != 9'd0))
        else $error("path step reported without a stored path");
endmodule

bind grid_astar_path_search gas_check u_gas_check (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_m_axis_tvalid(o_m_axis_tvalid),
    .i_m_axis_tready(i_m_axis_tready),
    .o_m_axis_tdata (o_m_axis_tdata)
);
